### hw/rtl/timed_release_order_queue_unit_macros.svh
// Assertion macros for the timed release order queue checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef TIMED_RELEASE_ORDER_QUEUE_UNIT_MACROS_SVH
`define TIMED_RELEASE_ORDER_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define TRQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/trq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the timed release order queue.
// No dependencies.
package trq_pkg;

   localparam int SEQ_WIDTH      = 32;
   localparam int TICK_CMD_WIDTH = 64;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_CANCEL  = 2'd1,
      OP_COLLECT = 2'd2,
      OP_DISCARD = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_RANGE     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] producer;
      logic [31:0] definition;
      logic [31:0] now;
      logic [31:0] duration;
      logic [31:0] sequence_req;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] assigned_sequence;
      logic        order_valid;
      logic [31:0] order_producer;
      logic [31:0] order_definition;
      logic [31:0] order_ready_at;
      logic [31:0] order_sequence;
      logic        last;
      logic [4:0]  pending;
   } rsp_item_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type                    op;
      logic [31:0]               producer;
      logic [31:0]               definition;
      logic [TICK_CMD_WIDTH-1:0] tick;
      logic [SEQ_WIDTH-1:0]      sequence_req;
      logic                      bad_arg;
      logic                      overflow;
   } cmd_type;

endpackage

### hw/rtl/trq_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, checks arguments and forms the ready tick.
// Depends on trq_pkg.
module trq_front import trq_pkg::*; #(
   parameter int TICK_WIDTH = 32
) (
   input  logic         req_valid,
   input  req_item_type req_item,
   input  logic         fifo_full,
   output logic         req_stall,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [TICK_WIDTH-1:0] now_t;
   logic [TICK_WIDTH-1:0] dur_t;
   logic [TICK_WIDTH:0]   sum;
   op_type                op;

   assign now_t = TICK_WIDTH'(req_item.now);
   assign dur_t = TICK_WIDTH'(req_item.duration);
   assign sum   = {1'b0, now_t} + {1'b0, dur_t};
   assign op    = op_type'(req_item.req_type);

   assign req_stall = fifo_full;
   assign push      = req_valid & ~fifo_full;

   always_comb begin
      push_cmd              = '0;
      push_cmd.op           = op;
      push_cmd.producer     = req_item.producer;
      push_cmd.definition   = req_item.definition;
      push_cmd.sequence_req = req_item.sequence_req;
      push_cmd.overflow     = sum[TICK_WIDTH];
      case (op)
         OP_ENQUEUE: begin
            push_cmd.bad_arg = (req_item.producer == '0) || (req_item.definition == '0);
            push_cmd.tick    = TICK_CMD_WIDTH'(sum[TICK_WIDTH-1:0]);
         end
         OP_CANCEL: begin
            push_cmd.bad_arg = (req_item.producer == '0);
         end
         OP_COLLECT: begin
            push_cmd.tick = TICK_CMD_WIDTH'(now_t);
         end
         default: begin
            push_cmd.bad_arg = 1'b0;
         end
      endcase
   end

endmodule

### hw/rtl/trq_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry command queue between front end and back end.
// Depends on trq_pkg.
module trq_cmd_fifo import trq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd,
   output logic    full
);

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_valid = (cnt_ff != 2'd0);
   assign full       = (cnt_ff == 2'd2);
   assign head_cmd   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/trq_back.sv
`timescale 1ns / 1ps
// Back end: order table memory, scan and compaction sequencer, result register.
// Depends on trq_pkg.
module trq_back import trq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TICK_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [31:0]           producer;
      logic [31:0]           definition;
      logic [TICK_WIDTH-1:0] ready;
      logic [SEQ_WIDTH-1:0]  seq;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_EVAL  = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   state_type            st_ff, st_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SEQ_WIDTH-1:0] seq_ff, seq_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        keep_ff, keep_in;
   logic [CW-1:0]        rel_ff, rel_in;
   logic [CW-1:0]        seen_ff, seen_in;
   logic                 found_ff, found_in;
   logic                 pass_ff, pass_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic      we;
   logic [IW-1:0] waddr;
   entry_type wdata;
   logic      load;
   rsp_item_type res;
   logic      slot_free;
   logic      last_idx;
   logic      due;
   logic      step;
   logic [CW-1:0] rel_next;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign last_idx  = (idx_ff == count_ff - CW'(1));
   assign due       = (rd_ff.ready <= cmd_ff.tick[TICK_WIDTH-1:0]);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      seq_in   = seq_ff;
      idx_in   = idx_ff;
      keep_in  = keep_ff;
      rel_in   = rel_ff;
      seen_in  = seen_ff;
      found_in = found_ff;
      pass_in  = pass_ff;
      we       = 1'b0;
      waddr    = keep_ff[IW-1:0];
      wdata    = rd_ff;
      pop      = 1'b0;
      load     = 1'b0;
      res      = '0;
      res.status = ST_OK;
      step     = 1'b1;
      rel_next = rel_ff;
      case (st_ff)
         S_IDLE: begin
            if (head_valid && slot_free) begin
               pop      = 1'b1;
               cmd_in   = head_cmd;
               idx_in   = '0;
               keep_in  = '0;
               rel_in   = '0;
               seen_in  = '0;
               found_in = 1'b0;
               pass_in  = 1'b0;
               res.last    = 1'b1;
               res.pending = 5'(count_ff);
               case (head_cmd.op)
                  OP_ENQUEUE: begin
                     load = 1'b1;
                     if (head_cmd.bad_arg) begin
                        res.status = ST_INVALID;
                     end else if (head_cmd.overflow || (seq_ff == '1)) begin
                        res.status = ST_RANGE;
                     end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                        res.status = ST_FULL;
                     end else begin
                        we    = 1'b1;
                        waddr = count_ff[IW-1:0];
                        wdata = '{producer:   head_cmd.producer,
                                  definition: head_cmd.definition,
                                  ready:      head_cmd.tick[TICK_WIDTH-1:0],
                                  seq:        seq_ff};
                        count_in = count_ff + CW'(1);
                        seq_in   = seq_ff + SEQ_WIDTH'(1);
                        res.assigned_sequence = seq_ff;
                        res.pending = 5'(count_ff + CW'(1));
                     end
                  end
                  OP_CANCEL: begin
                     if (head_cmd.bad_arg) begin
                        load       = 1'b1;
                        res.status = ST_INVALID;
                     end else begin
                        st_in = (count_ff == '0) ? S_FIN : S_ISSUE;
                     end
                  end
                  OP_COLLECT: begin
                     st_in = (count_ff == '0) ? S_FIN : S_ISSUE;
                  end
                  default: begin
                     load        = 1'b1;
                     count_in    = '0;
                     seq_in      = '0;
                     res.pending = 5'd0;
                  end
               endcase
            end
         end
         S_ISSUE: begin
            st_in = S_EVAL;
         end
         S_EVAL: begin
            if (cmd_ff.op == OP_CANCEL) begin
               if (!found_ff && (rd_ff.producer == cmd_ff.producer)
                   && (rd_ff.seq == cmd_ff.sequence_req)) begin
                  found_in = 1'b1;
               end else begin
                  we      = 1'b1;
                  keep_in = keep_ff + CW'(1);
               end
            end else if (!pass_ff) begin
               if (due) begin
                  rel_next = rel_ff + CW'(1);
               end
               rel_in = rel_next;
            end else if (due) begin
               // hold the scan while the result register holds a stalled response
               step = slot_free;
               if (slot_free) begin
                  load                 = 1'b1;
                  res.order_valid      = 1'b1;
                  res.order_producer   = rd_ff.producer;
                  res.order_definition = rd_ff.definition;
                  res.order_ready_at   = 32'(rd_ff.ready);
                  res.order_sequence   = rd_ff.seq;
                  res.last             = (seen_ff + CW'(1) == rel_ff);
                  res.pending          = 5'(count_ff - rel_ff);
                  seen_in              = seen_ff + CW'(1);
               end
            end else begin
               we      = 1'b1;
               keep_in = keep_ff + CW'(1);
            end
            if (step) begin
               if (last_idx) begin
                  if (cmd_ff.op == OP_CANCEL) begin
                     st_in = S_FIN;
                  end else if (!pass_ff) begin
                     if (rel_next == '0) begin
                        st_in = S_FIN;
                     end else begin
                        pass_in = 1'b1;
                        idx_in  = '0;
                        st_in   = S_ISSUE;
                     end
                  end else begin
                     count_in = count_ff - rel_ff;
                     st_in    = S_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  st_in  = S_ISSUE;
               end
            end
         end
         S_FIN: begin
            if (slot_free) begin
               load        = 1'b1;
               res.last    = 1'b1;
               res.pending = 5'(count_ff);
               if ((cmd_ff.op == OP_CANCEL) && !found_ff) begin
                  res.status = ST_NOT_FOUND;
               end else if (cmd_ff.op == OP_CANCEL) begin
                  count_in    = count_ff - CW'(1);
                  res.pending = 5'(count_ff - CW'(1));
               end
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         count_ff     <= '0;
         seq_ff       <= '0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         rel_ff       <= '0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         idx_ff       <= idx_in;
         keep_ff      <= keep_in;
         rel_ff       <= rel_in;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[idx_ff[IW-1:0]];
   end

endmodule

### hw/rtl/timed_release_order_queue_unit.sv
`timescale 1ns / 1ps
// Timed release order queue: holds up to QUEUE_DEPTH orders in arrival order.
// Enqueue and discard are answered from the idle state. Cancel walks the table
// once, reading each held entry through the registered read port of the table
// memory. Collect walks it once to count the due orders and, if any are due,
// again to release and compact; released orders leave one per walk step. A
// two-entry request queue lets new requests enter while the table is busy.
// Depends on trq_pkg, trq_front, trq_cmd_fifo and trq_back.
module timed_release_order_queue_unit import trq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TICK_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic    push;
   cmd_type push_cmd;
   logic    fifo_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   trq_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
      .req_valid (req_valid),
      .req_item  (req_item),
      .fifo_full (fifo_full),
      .req_stall (req_stall),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   trq_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (fifo_full)
   );

   trq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TICK_WIDTH(TICK_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

### hw/rtl/trq_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the timed release order queue, bound to the top level.
// Depends on trq_pkg and timed_release_order_queue_unit_macros.svh.
`include "timed_release_order_queue_unit_macros.svh"

module trq_checker import trq_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   logic req_wait;
   logic rsp_wait;
   logic plain_rsp;
   logic order_rsp;
   logic err_rsp;
   logic clean_rsp;

   assign req_wait  = req_valid && req_stall;
   assign rsp_wait  = rsp_valid && rsp_stall;
   assign plain_rsp = rsp_valid && !rsp_item.order_valid;
   assign order_rsp = rsp_valid && rsp_item.order_valid;
   assign err_rsp   = rsp_valid && (rsp_item.status != ST_OK);
   assign clean_rsp = !rsp_item.order_valid && (rsp_item.assigned_sequence == '0);

   `TRQ_ASSERT_NEXT(a_req_hold, req_wait, req_valid && $stable(req_item), "stalled request changed")
   `TRQ_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_item), "stalled response changed")
   `TRQ_ASSERT_NOW(a_single_last, plain_rsp, rsp_item.last, "non-order response without last")
   `TRQ_ASSERT_NOW(a_order_ok, order_rsp, rsp_item.status == ST_OK, "released order with error status")
   `TRQ_ASSERT_NOW(a_err_clean, err_rsp, clean_rsp, "error response carries data")

endmodule

bind timed_release_order_queue_unit trq_checker u_trq_checker (.*);
